// ===== hw/rtl/ncq_pkg.sv =====
// Shared types, constants and helpers for the navigation cell containment query.
package ncq_pkg;

  localparam int CELL_COUNT_DEF = 1024;
  localparam int CORNERS        = 3;
  localparam int COORD_W        = 32;
  localparam int LINK_W         = 11;
  localparam int IDX_W          = 10;
  localparam int ENTRY_W        = 3 * COORD_W + LINK_W;

  localparam logic [LINK_W-1:0] LINK_WALL = '1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_ON    = 2'd0,
    STATUS_OUT   = 2'd1,
    STATUS_BELOW = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic query;
    logic oob;
  } ctrl_t;

  function automatic logic signed [33:0] sx34(input logic signed [32:0] v);
    return {v[32], v};
  endfunction

endpackage

// ===== hw/rtl/navmesh_cell_containment_query.sv =====
// Each accepted query gives one result; loads give no result.
// Throughput: one item per cycle while no result waits on the output, one read port per corner RAM, one row per cell.
// The pipeline holds while a result waits on the output register.
// Reset clears the valid bits and the offset registers; the corner and
// neighbor tables are not cleared and read undefined until loaded.
module navmesh_cell_containment_query #(
  parameter int CELL_COUNT = ncq_pkg::CELL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                mode,
  input  logic [ncq_pkg::IDX_W-1:0]           cell_index,
  input  logic [1:0]                          corner,
  input  logic signed [ncq_pkg::COORD_W-1:0]  position_x,
  input  logic signed [ncq_pkg::COORD_W-1:0]  position_y,
  input  logic signed [ncq_pkg::COORD_W-1:0]  position_z,
  input  logic signed [ncq_pkg::LINK_W-1:0]   edge_link,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [1:0]                          status,
  output logic signed [ncq_pkg::LINK_W-1:0]   neighbor_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [ncq_pkg::COORD_W-1:0]         cfg_data
);

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  logic                  adv, accept, oob;
  logic [AW-1:0]         addr;
  logic [2:0]            we;
  logic [ncq_pkg::ENTRY_W-1:0] wdata;
  logic [ncq_pkg::ENTRY_W-1:0] entry [3];
  logic signed [31:0]    off_x, off_y, off_z;
  ncq_pkg::ctrl_t        ctrl_in;
  logic signed [31:0]    qx, qy, qz;
  ncq_pkg::status_t      res_status;
  logic [ncq_pkg::LINK_W-1:0] res_link;

  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;
  assign accept     = item_valid && adv;
  assign oob        = int'(cell_index) >= CELL_COUNT;
  assign addr       = AW'(cell_index);
  assign wdata      = {edge_link, position_z, position_y, position_x};
  assign cfg_ready  = 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      we[k] = accept && (mode == ncq_pkg::MODE_LOAD) && !oob && (corner == 2'(k));
    end
  end

  for (genvar k = 0; k < ncq_pkg::CORNERS; k++) begin : g_lane
    ncq_ram #(
      .W     (ncq_pkg::ENTRY_W),
      .DEPTH (CELL_COUNT),
      .AW    (AW)
    ) u_ram (
      .clk   (clk),
      .en    (adv),
      .we    (we[k]),
      .addr  (addr),
      .wdata (wdata),
      .rdata (entry[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_in <= '0;
      off_x   <= '0;
      off_y   <= '0;
      off_z   <= '0;
    end else begin
      if (adv) begin
        ctrl_in.valid <= accept;
        ctrl_in.query <= mode == ncq_pkg::MODE_QUERY;
        ctrl_in.oob   <= oob;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ncq_pkg::REG_OFFSET_X: off_x <= cfg_data;
          ncq_pkg::REG_OFFSET_Y: off_y <= cfg_data;
          ncq_pkg::REG_OFFSET_Z: off_z <= cfg_data;
          default: ;
        endcase
      end
    end
    if (adv) begin
      qx <= position_x;
      qy <= position_y;
      qz <= position_z;
    end
  end

  ncq_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctrl_in    (ctrl_in),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .entry      (entry),
    .off_x      (off_x),
    .off_y      (off_y),
    .off_z      (off_z),
    .res_valid  (result_valid),
    .res_status (res_status),
    .res_link   (res_link)
  );

  assign status         = res_status;
  assign neighbor_index = res_link;

  a_we_load: assert property (@(posedge clk) disable iff (rst)
    (we != 3'b000) |-> (accept && mode == ncq_pkg::MODE_LOAD && !oob))
    else $error("table write without accepted load");

  a_we_one: assert property (@(posedge clk) disable iff (rst) $onehot0(we))
    else $error("more than one corner lane written");

  a_wall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ncq_pkg::STATUS_OUT) |-> (neighbor_index == ncq_pkg::LINK_WALL))
    else $error("neighbor given without crossed edge");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !item_ready)
    else $error("item taken while pipeline holds");

endmodule

// ===== hw/rtl/ncq_ram.sv =====
// Generic single-port RAM with registered read.
module ncq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/ncq_geom.sv =====
// Edge side tests and surface height compare, pipelined over seven stages.
module ncq_geom (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  ncq_pkg::ctrl_t                        ctrl_in,
  input  logic signed [ncq_pkg::COORD_W-1:0]    qx,
  input  logic signed [ncq_pkg::COORD_W-1:0]    qy,
  input  logic signed [ncq_pkg::COORD_W-1:0]    qz,
  input  logic [ncq_pkg::ENTRY_W-1:0]           entry [3],
  input  logic signed [ncq_pkg::COORD_W-1:0]    off_x,
  input  logic signed [ncq_pkg::COORD_W-1:0]    off_y,
  input  logic signed [ncq_pkg::COORD_W-1:0]    off_z,
  output logic                                  res_valid,
  output ncq_pkg::status_t                      res_status,
  output logic [ncq_pkg::LINK_W-1:0]            res_link
);

  // stage a: world corners
  ncq_pkg::ctrl_t          a_ctrl;
  logic signed [32:0]      a_px [3];
  logic signed [32:0]      a_py [3];
  logic signed [32:0]      a_pz [3];
  logic [ncq_pkg::LINK_W-1:0] a_link [3];
  logic signed [31:0]      a_qx, a_qy, a_qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl <= '0;
    end else if (adv) begin
      a_ctrl <= ctrl_in;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_px[i]   <= {entry[i][31], entry[i][31:0]} + {off_x[31], off_x};
        a_py[i]   <= {entry[i][63], entry[i][63:32]} + {off_y[31], off_y};
        a_pz[i]   <= {entry[i][95], entry[i][95:64]} + {off_z[31], off_z};
        a_link[i] <= entry[i][ncq_pkg::ENTRY_W-1:96];
      end
      a_qx <= qx;
      a_qy <= qy;
      a_qz <= qz;
    end
  end

  // stage b: differences
  ncq_pkg::ctrl_t          b_ctrl;
  logic signed [33:0]      b_lx [3];
  logic signed [33:0]      b_lz [3];
  logic signed [33:0]      b_dx [3];
  logic signed [33:0]      b_dz [3];
  logic signed [33:0]      b_e1y, b_e2x, b_e2y, b_e2z, b_dy;
  logic [ncq_pkg::LINK_W-1:0] b_link [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl <= '0;
    end else if (adv) begin
      b_ctrl <= a_ctrl;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_lx[i]   <= ncq_pkg::sx34(a_px[(i + 1) % 3]) - ncq_pkg::sx34(a_px[i]);
        b_lz[i]   <= ncq_pkg::sx34(a_pz[(i + 1) % 3]) - ncq_pkg::sx34(a_pz[i]);
        b_dx[i]   <= 34'(a_qx) - ncq_pkg::sx34(a_px[i]);
        b_dz[i]   <= 34'(a_qz) - ncq_pkg::sx34(a_pz[i]);
        b_link[i] <= a_link[i];
      end
      b_e1y <= ncq_pkg::sx34(a_py[1]) - ncq_pkg::sx34(a_py[0]);
      b_e2x <= ncq_pkg::sx34(a_px[2]) - ncq_pkg::sx34(a_px[0]);
      b_e2y <= ncq_pkg::sx34(a_py[2]) - ncq_pkg::sx34(a_py[0]);
      b_e2z <= ncq_pkg::sx34(a_pz[2]) - ncq_pkg::sx34(a_pz[0]);
      b_dy  <= 34'(a_qy) - ncq_pkg::sx34(a_py[0]);
    end
  end

  // stage c: products
  ncq_pkg::ctrl_t          c_ctrl;
  logic signed [67:0]      c_sa [3];
  logic signed [67:0]      c_sb [3];
  logic signed [67:0]      c_nx0, c_nx1, c_ny0, c_ny1, c_nz0, c_nz1;
  logic signed [33:0]      c_dx, c_dy, c_dz;
  logic [ncq_pkg::LINK_W-1:0] c_link [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl <= '0;
    end else if (adv) begin
      c_ctrl <= b_ctrl;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_sa[i]   <= b_lx[i] * b_dz[i];
        c_sb[i]   <= b_lz[i] * b_dx[i];
        c_link[i] <= b_link[i];
      end
      c_nx0 <= b_e1y * b_e2z;
      c_nx1 <= b_lz[0] * b_e2y;
      c_ny0 <= b_lz[0] * b_e2x;
      c_ny1 <= b_lx[0] * b_e2z;
      c_nz0 <= b_lx[0] * b_e2y;
      c_nz1 <= b_e1y * b_e2x;
      c_dx  <= b_dx[0];
      c_dy  <= b_dy;
      c_dz  <= b_dz[0];
    end
  end

  // stage d: side tests and normal
  logic signed [68:0]      side [3];
  logic [2:0]              outside;
  logic [ncq_pkg::LINK_W-1:0] link_sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side[i]    = 69'(c_sa[i]) - 69'(c_sb[i]);
      outside[i] = !side[i][68] && (side[i] != '0);
    end
    if (outside[0]) begin
      link_sel = c_link[0];
    end else if (outside[1]) begin
      link_sel = c_link[1];
    end else begin
      link_sel = c_link[2];
    end
  end

  ncq_pkg::ctrl_t          d_ctrl;
  logic                    d_out;
  logic [ncq_pkg::LINK_W-1:0] d_link;
  logic signed [68:0]      d_nx, d_ny, d_nz;
  logic signed [33:0]      d_dx, d_dy, d_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctrl <= '0;
    end else if (adv) begin
      d_ctrl <= c_ctrl;
    end
    if (adv) begin
      d_out  <= |outside;
      d_link <= link_sel;
      d_nx   <= 69'(c_nx0) - 69'(c_nx1);
      d_ny   <= 69'(c_ny0) - 69'(c_ny1);
      d_nz   <= 69'(c_nz0) - 69'(c_nz1);
      d_dx   <= c_dx;
      d_dy   <= c_dy;
      d_dz   <= c_dz;
    end
  end

  // stage e: partial products of normal and offset
  logic signed [33:0]      nx_hi, ny_hi, nz_hi;
  logic signed [35:0]      nx_lo, ny_lo, nz_lo;

  assign nx_hi = d_nx[68:35];
  assign ny_hi = d_ny[68:35];
  assign nz_hi = d_nz[68:35];
  assign nx_lo = {1'b0, d_nx[34:0]};
  assign ny_lo = {1'b0, d_ny[34:0]};
  assign nz_lo = {1'b0, d_nz[34:0]};

  ncq_pkg::ctrl_t          e_ctrl;
  logic                    e_out, e_ny_zero, e_ny_pos;
  logic [ncq_pkg::LINK_W-1:0] e_link;
  logic signed [67:0]      e_xh, e_yh, e_zh;
  logic signed [69:0]      e_xl, e_yl, e_zl;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctrl <= '0;
    end else if (adv) begin
      e_ctrl <= d_ctrl;
    end
    if (adv) begin
      e_out     <= d_out;
      e_link    <= d_link;
      e_ny_zero <= (d_ny == '0);
      e_ny_pos  <= !d_ny[68] && (d_ny != '0);
      e_xh      <= nx_hi * d_dx;
      e_yh      <= ny_hi * d_dy;
      e_zh      <= nz_hi * d_dz;
      e_xl      <= nx_lo * 70'(d_dx);
      e_yl      <= ny_lo * 70'(d_dy);
      e_zl      <= nz_lo * 70'(d_dz);
    end
  end

  // stage f: full products
  ncq_pkg::ctrl_t          f_ctrl;
  logic                    f_out, f_ny_zero, f_ny_pos;
  logic [ncq_pkg::LINK_W-1:0] f_link;
  logic signed [105:0]     f_x, f_y, f_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctrl <= '0;
    end else if (adv) begin
      f_ctrl <= e_ctrl;
    end
    if (adv) begin
      f_out     <= e_out;
      f_link    <= e_link;
      f_ny_zero <= e_ny_zero;
      f_ny_pos  <= e_ny_pos;
      f_x       <= (106'(e_xh) <<< 35) + 106'(e_xl);
      f_y       <= (106'(e_yh) <<< 35) + 106'(e_yl);
      f_z       <= (106'(e_zh) <<< 35) + 106'(e_zl);
    end
  end

  // output stage: sign of nx*dx + ny*dy + nz*dz
  logic signed [105:0]     sum;
  logic                    below;
  ncq_pkg::status_t        status_next;
  logic [ncq_pkg::LINK_W-1:0] link_next;

  always_comb begin
    sum   = f_x + f_y + f_z;
    below = f_ny_pos ? sum[105] : (!sum[105] && (sum != '0));
    link_next = ncq_pkg::LINK_WALL;
    if (f_ctrl.oob) begin
      status_next = ncq_pkg::STATUS_OUT;
    end else if (f_out) begin
      status_next = ncq_pkg::STATUS_OUT;
      link_next   = f_link;
    end else if (f_ny_zero || !below) begin
      status_next = ncq_pkg::STATUS_ON;
    end else begin
      status_next = ncq_pkg::STATUS_BELOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= f_ctrl.valid && f_ctrl.query;
    end
    if (adv) begin
      res_status <= status_next;
      res_link   <= link_next;
    end
  end

endmodule

// ===== tb/sv/ncq_checker.sv =====
// Checker for the cell containment query: predicts each query answer and compares results.
`timescale 1ns / 100ps
module ncq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        mode,
  input  logic [9:0]  cell_index,
  input  logic [1:0]  corner,
  input  logic signed [31:0] position_x,
  input  logic signed [31:0] position_y,
  input  logic signed [31:0] position_z,
  input  logic signed [10:0] edge_link,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [1:0]  status,
  input  logic signed [10:0] neighbor_index,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    ncq_pkg::status_t st;
    logic [10:0]      link;
  } answer_t;

  logic signed [31:0] corner_x [3072];
  logic signed [31:0] corner_y [3072];
  logic signed [31:0] corner_z [3072];
  logic [10:0]        corner_link [3072];
  logic signed [31:0] world_x, world_y, world_z;
  answer_t            answers_due [$];

  assign pending = answers_due.size();

  function automatic answer_t locate(input int cell_id, input logic signed [31:0] qx_in,
                                     input logic signed [31:0] qy_in,
                                     input logic signed [31:0] qz_in);
    logic signed [127:0] px [4];
    logic signed [127:0] py [4];
    logic signed [127:0] pz [4];
    logic signed [127:0] qx, qy, qz, side, nx, ny, nz, num, rhs;
    logic signed [127:0] ox, oy, oz;
    answer_t a;
    ox = world_x;
    oy = world_y;
    oz = world_z;
    qx = qx_in;
    qy = qy_in;
    qz = qz_in;
    for (int i = 0; i < 3; i++) begin
      px[i] = corner_x[cell_id*3+i];
      py[i] = corner_y[cell_id*3+i];
      pz[i] = corner_z[cell_id*3+i];
      px[i] = px[i] + ox;
      py[i] = py[i] + oy;
      pz[i] = pz[i] + oz;
    end
    px[3] = px[0];
    py[3] = py[0];
    pz[3] = pz[0];
    for (int i = 0; i < 3; i++) begin
      side = -(pz[i+1] - pz[i]) * (qx - px[i]) + (px[i+1] - px[i]) * (qz - pz[i]);
      if (side > 0) begin
        a.st = ncq_pkg::STATUS_OUT;
        a.link = corner_link[cell_id*3+i];
        return a;
      end
    end
    nx = (py[1]-py[0]) * (pz[2]-pz[0]) - (pz[1]-pz[0]) * (py[2]-py[0]);
    ny = (pz[1]-pz[0]) * (px[2]-px[0]) - (px[1]-px[0]) * (pz[2]-pz[0]);
    nz = (px[1]-px[0]) * (py[2]-py[0]) - (py[1]-py[0]) * (px[2]-px[0]);
    a.link = ncq_pkg::LINK_WALL;
    a.st = ncq_pkg::STATUS_ON;
    if (ny != 0) begin
      num = -(nx * (qx - px[0]) + nz * (qz - pz[0]));
      rhs = ny * (qy - py[0]);
      if ((ny > 0) ? (num > rhs) : (rhs > num)) a.st = ncq_pkg::STATUS_BELOW;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      world_x <= '0;
      world_y <= '0;
      world_z <= '0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ncq_pkg::REG_OFFSET_X: world_x <= cfg_data;
          ncq_pkg::REG_OFFSET_Y: world_y <= cfg_data;
          ncq_pkg::REG_OFFSET_Z: world_z <= cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        if (mode == ncq_pkg::MODE_LOAD) begin
          if (corner < 2'd3) begin
            corner_x[cell_index*3+corner] <= position_x;
            corner_y[cell_index*3+corner] <= position_y;
            corner_z[cell_index*3+corner] <= position_z;
            corner_link[cell_index*3+corner] <= edge_link;
          end
        end else begin
          answers_due.push_back(locate(cell_index, position_x, position_y, position_z));
        end
      end
      if (result_valid && result_ready) begin
        if (answers_due.size() == 0) begin
          if (errors < 10) $display("unexpected result: status %0d neighbor %0d",
                                    status, neighbor_index);
          errors <= errors + 1;
        end else begin
          answer_t want;
          want = answers_due.pop_front();
          if (status !== want.st || neighbor_index !== want.link) begin
            if (errors < 10)
              $display("mismatch: status exp %0d got %0d, neighbor exp %0d got %0d",
                       want.st, status, $signed(want.link), neighbor_index);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the cell containment query testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

  localparam int UNIT = 65536;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic mode = ncq_pkg::MODE_LOAD;
  logic [9:0] cell_index = '0;
  logic [1:0] corner = '0;
  logic signed [31:0] position_x = '0;
  logic signed [31:0] position_y = '0;
  logic signed [31:0] position_z = '0;
  logic signed [10:0] edge_link = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [1:0] status;
  logic signed [10:0] neighbor_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  int ready_hold = 0;
  bit steady = 1'b0;
  logic [2:0] loaded [1024];
  int centers_x [1024];
  int centers_y [1024];
  int centers_z [1024];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  navmesh_cell_containment_query dut (.*);

  ncq_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("navmesh_cell_containment_query test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (steady) begin
      result_ready = 1'b1;
    end else if (ready_hold == 0) begin
      result_ready = ($urandom_range(0, 2) != 0);
      ready_hold = $urandom_range(1, 19);
    end else begin
      ready_hold = ready_hold - 1;
    end
  end

  task automatic transfer_item(input logic m, input int cell_id, input int crn,
                               input int x, input int y, input int z, input int link);
    @(negedge clk);
    if (!steady && $urandom_range(0, 3) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    mode = m;
    cell_index = 10'(cell_id);
    corner = 2'(crn);
    position_x = x;
    position_y = y;
    position_z = z;
    edge_link = 11'(link);
    item_valid = 1'b1;
    if (m == ncq_pkg::MODE_LOAD && crn < 3) loaded[cell_id][crn] = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int data);
    @(negedge clk);
    item_valid = 1'b0;
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_offsets(input int ox, input int oy, input int oz);
    write_reg(ncq_pkg::REG_OFFSET_X, ox);
    write_reg(ncq_pkg::REG_OFFSET_Y, oy);
    write_reg(ncq_pkg::REG_OFFSET_Z, oz);
    write_reg(REG_SPARE, $urandom);
  endtask

  function automatic int link_pick();
    return ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, 1023);
  endfunction

  task automatic build_cell(input int cell_id);
    int span, cx, cy, cz;
    span = 1 << $urandom_range(4, 24);
    cx = $urandom_range(0, 1 << 30) - (1 << 29);
    cy = $urandom_range(0, 1 << 30) - (1 << 29);
    cz = $urandom_range(0, 1 << 30) - (1 << 29);
    centers_x[cell_id] = cx;
    centers_y[cell_id] = cy;
    centers_z[cell_id] = cz;
    for (int k = 0; k < 3; k++)
      transfer_item(ncq_pkg::MODE_LOAD, cell_id, k, cx + $urandom_range(0, 2*span) - span,
                    cy + $urandom_range(0, 2*span) - span,
                    cz + $urandom_range(0, 2*span) - span, link_pick());
  endtask

  task automatic random_phase(input int count);
    int sent, cell_id, span;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: begin
          transfer_item(ncq_pkg::MODE_LOAD, $urandom_range(0, 1023), $urandom_range(0, 3),
                        $urandom, $urandom, $urandom, link_pick());
          sent++;
        end
        1: begin
          cell_id = $urandom_range(0, 1023);
          if (loaded[cell_id] == 3'b111) begin
            transfer_item(ncq_pkg::MODE_QUERY, cell_id, $urandom_range(0, 3), $urandom,
                          $urandom, $urandom, $urandom_range(0, 2047));
            sent++;
          end
        end
        default: begin
          cell_id = $urandom_range(0, 1023);
          if (loaded[cell_id] != 3'b111 || $urandom_range(0, 2) == 0) begin
            build_cell(cell_id);
            sent += 3;
          end
          span = 1 << $urandom_range(4, 25);
          repeat ($urandom_range(1, 4)) begin
            transfer_item(ncq_pkg::MODE_QUERY, cell_id, $urandom_range(0, 3),
                          centers_x[cell_id] + $urandom_range(0, 2*span) - span,
                          centers_y[cell_id] + $urandom_range(0, 2*span) - span,
                          centers_z[cell_id] + $urandom_range(0, 2*span) - span,
                          $urandom_range(0, 2047));
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 1024; i++) loaded[i] = 3'b000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_offsets(0, 0, 0);

    transfer_item(ncq_pkg::MODE_LOAD, 0, 0, 0, 5*UNIT, 0, -1);
    transfer_item(ncq_pkg::MODE_LOAD, 0, 1, 0, 5*UNIT, 10*UNIT, 1023);
    transfer_item(ncq_pkg::MODE_LOAD, 0, 2, 10*UNIT, 5*UNIT, 0, 5);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, UNIT, 0, UNIT, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, UNIT, 9*UNIT, UNIT, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, UNIT, 5*UNIT, UNIT, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, -UNIT, 0, UNIT, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, 9*UNIT, 0, 9*UNIT, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, UNIT, 0, -UNIT, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0);
    transfer_item(ncq_pkg::MODE_LOAD, 0, 3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, -1);
    transfer_item(ncq_pkg::MODE_QUERY, 0, 3, UNIT, 0, UNIT, 0);
    for (int k = 0; k < 3; k++)
      transfer_item(ncq_pkg::MODE_LOAD, 1, k, 3*UNIT, 3*UNIT, 3*UNIT, 7);
    transfer_item(ncq_pkg::MODE_QUERY, 1, 0, 3*UNIT, -UNIT, 3*UNIT, 0);
    transfer_item(ncq_pkg::MODE_LOAD, 1023, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                  1023);
    transfer_item(ncq_pkg::MODE_LOAD, 1023, 1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, -1);
    transfer_item(ncq_pkg::MODE_LOAD, 1023, 2, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    transfer_item(ncq_pkg::MODE_QUERY, 1023, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                  -1);
    transfer_item(ncq_pkg::MODE_QUERY, 1023, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  -1);
    transfer_item(ncq_pkg::MODE_QUERY, 1023, 0, -UNIT, 32'h80000000, -UNIT, -1);
    random_phase(240);

    drain();
    set_offsets(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    transfer_item(ncq_pkg::MODE_QUERY, 1023, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    random_phase(250);
    drain();
    set_offsets(32'h80000000, 32'h80000000, 32'h80000000);
    transfer_item(ncq_pkg::MODE_QUERY, 1023, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    random_phase(250);
    drain();
    set_offsets($urandom, $urandom, $urandom);
    random_phase(250);
    drain();
    set_offsets($urandom_range(0, 1 << 20), -$urandom_range(0, 1 << 20), $urandom);
    steady = 1'b1;
    random_phase(250);
    drain();

    if (errors == 0)
      $display("navmesh_cell_containment_query test passed");
    else
      $display("navmesh_cell_containment_query test failed");
    $finish;
  end
endmodule
